[rtl/core/tpq_pkg.sv]
package tpq_pkg;

  localparam int AGE_W = 7;
  localparam int TAG_W = 16;
  localparam int CNT_W = 5;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd1;

  localparam logic [AGE_W-1:0] UPPER_RST = 7'd80;
  localparam logic [AGE_W-1:0] LOWER_RST = 7'd60;

  // Function codes.
  localparam logic FUNC_ENQ   = 1'b0;
  localparam logic FUNC_SERVE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_ENQ   = 2'd0;
  localparam logic [1:0] ST_SERVE = 2'd1;
  localparam logic [1:0] ST_DROP  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  // Class codes.
  localparam logic [1:0] CLS_HIGH = 2'd0;
  localparam logic [1:0] CLS_MID  = 2'd1;
  localparam logic [1:0] CLS_LOW  = 2'd2;

  localparam int NUM_CLASSES = 3;
  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic             func;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [1:0]       out_class;
    logic [AGE_W-1:0] out_age;
    logic [TAG_W-1:0] out_tag;
    logic [CNT_W-1:0] high_count;
    logic [CNT_W-1:0] middle_count;
    logic [CNT_W-1:0] low_count;
  } out_item_t;

  // Classified operation passed from the front end to the execution side.
  typedef struct packed {
    logic             serve;
    logic [1:0]       cls;
    logic [AGE_W-1:0] age;
    logic [TAG_W-1:0] tag;
  } op_t;

endpackage

[rtl/core/tpq_front.sv]
module tpq_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tpq_pkg::in_item_t              in_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpq_pkg::AGE_W-1:0]      cfg_wdata,
  output logic                           push_valid,
  input  logic                           push_ready,
  output tpq_pkg::op_t                   push_data
);

  logic [tpq_pkg::AGE_W-1:0] upper_r;
  logic [tpq_pkg::AGE_W-1:0] lower_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= tpq_pkg::UPPER_RST;
      lower_r <= tpq_pkg::LOWER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpq_pkg::CFG_UPPER: upper_r <= cfg_wdata;
        tpq_pkg::CFG_LOWER: lower_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The upper test wins, so an inverted threshold pair is not reordered.
  always_comb begin
    push_data.serve = (in_data.func == tpq_pkg::FUNC_SERVE);
    push_data.age   = in_data.age;
    push_data.tag   = in_data.tag;
    if (in_data.age >= upper_r) begin
      push_data.cls = tpq_pkg::CLS_HIGH;
    end else if (in_data.age >= lower_r) begin
      push_data.cls = tpq_pkg::CLS_MID;
    end else begin
      push_data.cls = tpq_pkg::CLS_LOW;
    end
  end

  assign push_valid = in_valid;
  assign in_stall   = !push_ready;

endmodule

[rtl/core/tpq_fifo.sv]
module tpq_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  tpq_pkg::op_t push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output tpq_pkg::op_t pop_data
);

  localparam int PW = $clog2(tpq_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(tpq_pkg::FIFO_DEPTH + 1);

  tpq_pkg::op_t  slots_r [tpq_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(tpq_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (count_r != CW'(tpq_pkg::FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/core/tpq_back.sv]
module tpq_back #(
  parameter int CLASS_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  output logic               op_ready,
  input  tpq_pkg::op_t       op_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tpq_pkg::out_item_t out_data
);

  localparam int IW = $clog2(CLASS_DEPTH);
  localparam int CW = $clog2(CLASS_DEPTH + 1);
  localparam int MEM_DEPTH = tpq_pkg::NUM_CLASSES * CLASS_DEPTH;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int EW = tpq_pkg::AGE_W + tpq_pkg::TAG_W;
  localparam logic [AW-1:0] BASE_MID = AW'(CLASS_DEPTH);
  localparam logic [AW-1:0] BASE_LOW = AW'(2 * CLASS_DEPTH);

  logic [EW-1:0] mem [MEM_DEPTH];
  logic [EW-1:0] rdata_r;

  logic [CW-1:0] occ_r  [tpq_pkg::NUM_CLASSES];
  logic [CW-1:0] occ_nxt[tpq_pkg::NUM_CLASSES];
  logic [IW-1:0] head_r  [tpq_pkg::NUM_CLASSES];
  logic [IW-1:0] head_nxt[tpq_pkg::NUM_CLASSES];
  logic [IW-1:0] tail_r  [tpq_pkg::NUM_CLASSES];
  logic [IW-1:0] tail_nxt[tpq_pkg::NUM_CLASSES];

  logic          fire;
  logic          mem_we;
  logic          mem_re;
  logic [1:0]    sel_cls;
  logic [IW-1:0] slot;
  logic [AW-1:0] base;
  logic [AW-1:0] addr;
  logic [1:0]    res_status;

  logic                      out_valid_r;
  logic [1:0]                status_r;
  logic [1:0]                cls_r;
  logic [tpq_pkg::CNT_W-1:0] cnt_r [tpq_pkg::NUM_CLASSES];

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    return (i == IW'(CLASS_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign op_ready = !out_valid_r || !out_stall;
  assign fire     = op_valid && op_ready;

  always_comb begin
    occ_nxt    = occ_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    sel_cls    = op_data.cls;
    slot       = tail_r[op_data.cls];
    res_status = tpq_pkg::ST_ENQ;
    if (!op_data.serve) begin
      if (occ_r[op_data.cls] == CW'(CLASS_DEPTH)) begin
        res_status = tpq_pkg::ST_DROP;
      end else begin
        mem_we                 = fire;
        tail_nxt[op_data.cls]  = next_slot(tail_r[op_data.cls]);
        occ_nxt[op_data.cls]   = occ_r[op_data.cls] + 1'b1;
      end
    end else begin
      res_status = tpq_pkg::ST_SERVE;
      if (occ_r[tpq_pkg::CLS_HIGH] != '0) begin
        sel_cls = tpq_pkg::CLS_HIGH;
      end else if (occ_r[tpq_pkg::CLS_MID] != '0) begin
        sel_cls = tpq_pkg::CLS_MID;
      end else if (occ_r[tpq_pkg::CLS_LOW] != '0) begin
        sel_cls = tpq_pkg::CLS_LOW;
      end else begin
        sel_cls    = tpq_pkg::CLS_HIGH;
        res_status = tpq_pkg::ST_EMPTY;
      end
      slot = head_r[sel_cls];
      if (res_status == tpq_pkg::ST_SERVE) begin
        mem_re            = fire;
        head_nxt[sel_cls] = next_slot(head_r[sel_cls]);
        occ_nxt[sel_cls]  = occ_r[sel_cls] - 1'b1;
      end
    end
  end

  always_comb begin
    case (sel_cls)
      tpq_pkg::CLS_MID: base = BASE_MID;
      tpq_pkg::CLS_LOW: base = BASE_LOW;
      default:          base = '0;
    endcase
  end

  assign addr = base + AW'(slot);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= {op_data.age, op_data.tag};
    end
    if (mem_re) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < tpq_pkg::NUM_CLASSES; c++) begin
        occ_r[c]  <= '0;
        head_r[c] <= '0;
        tail_r[c] <= '0;
      end
    end else if (fire) begin
      occ_r  <= occ_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= res_status;
      cls_r    <= sel_cls;
      for (int c = 0; c < tpq_pkg::NUM_CLASSES; c++) begin
        cnt_r[c] <= tpq_pkg::CNT_W'(occ_nxt[c]);
      end
    end
  end

  always_comb begin
    out_data.status       = status_r;
    out_data.out_class    = cls_r;
    out_data.high_count   = cnt_r[tpq_pkg::CLS_HIGH];
    out_data.middle_count = cnt_r[tpq_pkg::CLS_MID];
    out_data.low_count    = cnt_r[tpq_pkg::CLS_LOW];
    if (status_r == tpq_pkg::ST_SERVE) begin
      {out_data.out_age, out_data.out_tag} = rdata_r;
    end else begin
      out_data.out_age = '0;
      out_data.out_tag = '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/core/three_class_priority_queue_core.sv]
// Channel   Direction  Handshake          Beat contents
// in_*      input      in_valid/in_stall  func, age, tag (tpq_pkg::in_item_t)
// out_*     output     out_valid/out_stall status, class, entry, three counts
// cfg_*     input      cfg_valid/cfg_ready threshold index and 7-bit value
//
// The block sustains one beat per cycle on both sides while the output is not
// stalled. A beat accepted on the input sits in a two-entry queue, is executed
// against the class stores when the execution unit takes it, and its result is
// loaded into the output register as it executes.
// The execution unit touches at most one entry of the single-port entry
// memory per beat, which sets the rate at one item per cycle unless stalled.
// Reset is synchronous and active low. It clears the pointers and counts at
// once; the entry memory is not cleared, since no entry is read before it is
// written. A stalled output holds its register and stops the execution unit;
// the input stalls only once the queue between the two sides is full.
module three_class_priority_queue_core #(
  parameter int CLASS_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tpq_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tpq_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpq_pkg::AGE_W-1:0]      cfg_wdata
);

  // Classified operations travel from the front end through the queue.
  logic         push_valid;
  logic         push_ready;
  tpq_pkg::op_t push_data;
  logic         pop_valid;
  logic         pop_ready;
  tpq_pkg::op_t pop_data;

  // The front end owns the thresholds and assigns each beat its class.
  tpq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // A short queue decouples input acceptance from output back-pressure.
  tpq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end keeps the three FIFO classes and produces each result.
  tpq_back #(
    .CLASS_DEPTH (CLASS_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (pop_valid),
    .op_ready  (pop_ready),
    .op_data   (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Nothing to serve means every class was empty and stays empty.
  a_empty_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == tpq_pkg::ST_EMPTY) |->
      (out_data.high_count == '0 && out_data.middle_count == '0 &&
       out_data.low_count == '0))
    else $error("empty status with nonzero occupancy");

  // Strict priority: serving a lower class implies the high class is empty.
  a_strict_priority: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == tpq_pkg::ST_SERVE &&
     out_data.out_class != tpq_pkg::CLS_HIGH) |-> (out_data.high_count == '0))
    else $error("lower class served while high class occupied");

  // A drop from the low class happens only when that class is full.
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == tpq_pkg::ST_DROP &&
     out_data.out_class == tpq_pkg::CLS_LOW) |->
      (out_data.low_count == tpq_pkg::CNT_W'(CLASS_DEPTH)))
    else $error("low class drop without full occupancy");

  // The input stalls only after a beat has been pushed into the queue.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall raised without a preceding beat");

endmodule
